/* design/utph_pkg.sv */
`timescale 1ns / 1ps
// utph_pkg: shared types and codes for the uTP header parser.
// Used by utph_parse_step and utp_header_parser_core; depends on nothing.
package utph_pkg;

	localparam int HEADER_BYTES = 20;
	localparam int POS_W = 5;

	// parser phase, one-hot
	typedef enum logic [5:0] {
		PH_HEADER   = 6'b000001,
		PH_EXT_NEXT = 6'b000010,
		PH_EXT_LEN  = 6'b000100,
		PH_EXT_BODY = 6'b001000,
		PH_PAYLOAD  = 6'b010000,
		PH_DISCARD  = 6'b100000
	} phase_t;

	// byte class codes
	localparam logic [2:0] CLS_HEADER   = 3'd0;
	localparam logic [2:0] CLS_EXT_NEXT = 3'd1;
	localparam logic [2:0] CLS_EXT_LEN  = 3'd2;
	localparam logic [2:0] CLS_EXT_BODY = 3'd3;
	localparam logic [2:0] CLS_PAYLOAD  = 3'd4;
	localparam logic [2:0] CLS_DISCARD  = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_VERSION = 2'd1;
	localparam logic [1:0] ST_TRUNC   = 2'd2;

	// register map
	localparam logic REG_EXPECTED_VERSION = 1'b0;
	localparam logic [3:0] EXPECTED_VERSION_RST = 4'd1;

	typedef struct packed {
		phase_t             phase;
		logic [POS_W-1:0]   hdr_pos;
		logic [7:0]         cur_ext;
		logic [7:0]         next_ext;
		logic [7:0]         body_rem;
		logic [1:0]         err;
		logic [3:0]         pkt_type;
		logic [15:0]        conn_id;
		logic [31:0]        stamp;
		logic [31:0]        stamp_diff;
		logic [31:0]        window;
		logic [15:0]        seq;
		logic [15:0]        ack;
	} parse_state_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [2:0]  byte_class;
		logic [7:0]  ext_code;
		logic [3:0]  packet_type;
		logic [15:0] conn_ident;
		logic [31:0] stamp_us;
		logic [31:0] stamp_delta_us;
		logic [31:0] window_size;
		logic [15:0] seq_number;
		logic [15:0] ack_number;
		logic [1:0]  status;
		logic        end_of_packet;
	} result_t;

endpackage

/* design/utph_parse_step.sv */
`timescale 1ns / 1ps
// utph_parse_step: next-state and result logic for one datagram byte.
// Depends on utph_pkg.
module utph_parse_step (
	input  utph_pkg::parse_state_t cur,
	input  logic [7:0]             byte_value,
	input  logic                   last_byte,
	input  logic [3:0]             expected_version,
	output utph_pkg::parse_state_t nxt,
	output utph_pkg::result_t      res
);

	logic       trunc;
	logic [2:0] cls;
	logic [7:0] ext;
	logic [7:0] body_dec;

	assign body_dec = cur.body_rem - 8'd1;

	always_comb begin
		nxt   = cur;
		trunc = 1'b0;
		cls   = utph_pkg::CLS_DISCARD;
		ext   = 8'd0;

		case (cur.phase)
			utph_pkg::PH_HEADER: begin
				cls = utph_pkg::CLS_HEADER;
				case (cur.hdr_pos) inside
					5'd0: begin
						nxt.pkt_type = byte_value[7:4];
						if (byte_value[3:0] != expected_version) begin
							nxt.err = utph_pkg::ST_VERSION;
						end
					end
					5'd1:     nxt.next_ext   = byte_value;
					[5'd2:5'd3]:   nxt.conn_id    = {cur.conn_id[7:0], byte_value};
					[5'd4:5'd7]:   nxt.stamp      = {cur.stamp[23:0], byte_value};
					[5'd8:5'd11]:  nxt.stamp_diff = {cur.stamp_diff[23:0], byte_value};
					[5'd12:5'd15]: nxt.window     = {cur.window[23:0], byte_value};
					[5'd16:5'd17]: nxt.seq        = {cur.seq[7:0], byte_value};
					default:  nxt.ack        = {cur.ack[7:0], byte_value};
				endcase
				if (nxt.err == utph_pkg::ST_VERSION) begin
					nxt.phase = utph_pkg::PH_DISCARD;
				end else if (cur.hdr_pos >= 5'(utph_pkg::HEADER_BYTES - 1)) begin
					nxt.phase = (nxt.next_ext != 8'd0) ? utph_pkg::PH_EXT_NEXT
						: utph_pkg::PH_PAYLOAD;
				end else begin
					nxt.hdr_pos = cur.hdr_pos + 5'd1;
					trunc = last_byte;
				end
			end
			utph_pkg::PH_EXT_NEXT: begin
				cls          = utph_pkg::CLS_EXT_NEXT;
				nxt.cur_ext  = cur.next_ext;
				nxt.next_ext = byte_value;
				ext          = cur.next_ext;
				nxt.phase    = utph_pkg::PH_EXT_LEN;
				trunc        = last_byte;
			end
			utph_pkg::PH_EXT_LEN: begin
				cls          = utph_pkg::CLS_EXT_LEN;
				ext          = cur.cur_ext;
				nxt.body_rem = byte_value;
				if (byte_value != 8'd0) begin
					nxt.phase = utph_pkg::PH_EXT_BODY;
					trunc     = last_byte;
				end else begin
					nxt.phase = (cur.next_ext != 8'd0) ? utph_pkg::PH_EXT_NEXT
						: utph_pkg::PH_PAYLOAD;
				end
			end
			utph_pkg::PH_EXT_BODY: begin
				cls          = utph_pkg::CLS_EXT_BODY;
				ext          = cur.cur_ext;
				nxt.body_rem = body_dec;
				if (body_dec == 8'd0) begin
					nxt.phase = (cur.next_ext != 8'd0) ? utph_pkg::PH_EXT_NEXT
						: utph_pkg::PH_PAYLOAD;
				end else begin
					trunc = last_byte;
				end
			end
			utph_pkg::PH_PAYLOAD: begin
				cls = utph_pkg::CLS_PAYLOAD;
			end
			default: begin
				cls = utph_pkg::CLS_DISCARD;
			end
		endcase

		// mismatch wins over truncation
		if (trunc && nxt.err == utph_pkg::ST_OK) begin
			nxt.err = utph_pkg::ST_TRUNC;
		end

		res.out_byte       = byte_value;
		res.byte_class     = cls;
		res.ext_code       = ext;
		res.packet_type    = nxt.pkt_type;
		res.conn_ident     = nxt.conn_id;
		res.stamp_us       = nxt.stamp;
		res.stamp_delta_us = nxt.stamp_diff;
		res.window_size    = nxt.window;
		res.seq_number     = nxt.seq;
		res.ack_number     = nxt.ack;
		res.status         = nxt.err;
		res.end_of_packet  = last_byte;

		// datagram done: per-packet state back to reset, header fields kept
		if (last_byte) begin
			nxt.phase    = utph_pkg::PH_HEADER;
			nxt.hdr_pos  = '0;
			nxt.cur_ext  = 8'd0;
			nxt.next_ext = 8'd0;
			nxt.body_rem = 8'd0;
			nxt.err      = utph_pkg::ST_OK;
		end
	end

endmodule

/* design/utp_header_parser_core.sv */
`timescale 1ns / 1ps
// utp_header_parser_core: top level of the uTP datagram header parser.
// Depends on utph_pkg and utph_parse_step.
//
//  channel   direction  handshake                    payload
//  item      in         item_valid / item_ready      byte_value, last_byte
//  result    out        result_valid / result_ready  out_byte ... end_of_packet
//  config    in         APB psel/penable/pready      paddr, pwdata, prdata
//
// One byte per cycle while item_ready is high; its result appears in the output
// register in the cycle after acceptance. The parse state updates in the accepting cycle.
// item_ready is low only while a result waits and result_ready is low.
// arst_n clears parse state, header fields and the output register;
// expected_version resets to 1.
module utp_header_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// byte requests
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	// results
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  out_byte,
	output logic [2:0]  byte_class,
	output logic [7:0]  ext_code,
	output logic [3:0]  packet_type,
	output logic [15:0] conn_ident,
	output logic [31:0] stamp_us,
	output logic [31:0] stamp_delta_us,
	output logic [31:0] window_size,
	output logic [15:0] seq_number,
	output logic [15:0] ack_number,
	output logic [1:0]  status,
	output logic        end_of_packet
);

	logic [3:0]             exp_ver_q;
	utph_pkg::parse_state_t state_q;
	utph_pkg::parse_state_t state_nxt;
	utph_pkg::result_t      res_nxt;
	utph_pkg::result_t      res_q;
	logic                   res_valid_q;
	logic                   accept;
	logic                   cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == utph_pkg::REG_EXPECTED_VERSION) ? {28'd0, exp_ver_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_ver_q <= utph_pkg::EXPECTED_VERSION_RST;
		end else if (cfg_wr && paddr[2] == utph_pkg::REG_EXPECTED_VERSION) begin
			exp_ver_q <= pwdata[3:0];
		end
	end

	assign item_ready = !res_valid_q || result_ready;
	assign accept     = item_valid && item_ready;

	utph_parse_step u_step (
		.cur              (state_q),
		.byte_value       (byte_value),
		.last_byte        (last_byte),
		.expected_version (exp_ver_q),
		.nxt              (state_nxt),
		.res              (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: utph_pkg::PH_HEADER, default: '0};
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (accept) begin
			res_q <= res_nxt;
		end
	end

	assign result_valid   = res_valid_q;
	assign out_byte       = res_q.out_byte;
	assign byte_class     = res_q.byte_class;
	assign ext_code       = res_q.ext_code;
	assign packet_type    = res_q.packet_type;
	assign conn_ident     = res_q.conn_ident;
	assign stamp_us       = res_q.stamp_us;
	assign stamp_delta_us = res_q.stamp_delta_us;
	assign window_size    = res_q.window_size;
	assign seq_number     = res_q.seq_number;
	assign ack_number     = res_q.ack_number;
	assign status         = res_q.status;
	assign end_of_packet  = res_q.end_of_packet;

`ifndef ASSERT_OFF
	a_eop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> state_q.phase == utph_pkg::PH_HEADER
			&& state_q.hdr_pos == '0 && state_q.err == utph_pkg::ST_OK)
		else $error("packet state not cleared after last byte");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result_valid)
		else $error("accepted byte produced no result");

	a_discard_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && byte_class == utph_pkg::CLS_DISCARD
			|-> status == utph_pkg::ST_VERSION)
		else $error("discarded byte without version mismatch");

	a_ext_code_scope: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && ext_code != 8'd0 |-> byte_class == utph_pkg::CLS_EXT_NEXT
			|| byte_class == utph_pkg::CLS_EXT_LEN || byte_class == utph_pkg::CLS_EXT_BODY)
		else $error("extension type outside extension bytes");
`endif

endmodule
